// ----- rtl/dsi_pkg.sv -----
// ----------------------------------------------------------------------------
// dsi_pkg
// shared types and constants of the daylight schedule interpolator
// ----------------------------------------------------------------------------
package dsi_pkg;

	localparam int POS_W = 24;
	localparam int TIME_W = 32;
	localparam int COLOR_W = 16;
	localparam int BRI_W = 8;

	localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

	// breakpoint setting word, on in bit 40 down to x in bits 15..0
	typedef struct packed {
		logic               on;
		logic [BRI_W-1:0]   bri;
		logic [COLOR_W-1:0] y;
		logic [COLOR_W-1:0] x;
	} setting_t;

	typedef enum logic [1:0] {
		ST_EVAL   = 2'd0,
		ST_STORED = 2'd1,
		ST_SPAN   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_EVAL = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		CFG_SUNRISE = 2'd0,
		CFG_SUNSET  = 2'd1,
		CFG_COUNT   = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_READ,
		S_CMP,
		S_LERP
	} state_t;

endpackage

// ----- rtl/dsi_table.sv -----
// ----------------------------------------------------------------------------
// dsi_table
// breakpoint store: position and setting memories, one write and one
// registered read port each
// ----------------------------------------------------------------------------
module dsi_table import dsi_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [AW-1:0]           wr_addr,
	input  logic signed [POS_W-1:0] wr_pos,
	input  setting_t                wr_set,
	input  logic [AW-1:0]           rd_addr,
	output logic signed [POS_W-1:0] rd_pos,
	output setting_t                rd_set
);

	logic signed [POS_W-1:0] pos_mem [DEPTH];
	setting_t                set_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_mem[wr_addr] <= wr_pos;
			set_mem[wr_addr] <= wr_set;
		end
	end

	always_ff @(posedge clk) begin
		rd_pos <= pos_mem[rd_addr];
		rd_set <= set_mem[rd_addr];
	end

endmodule

// ----- rtl/dsi_pos_div.sv -----
// ----------------------------------------------------------------------------
// dsi_pos_div
// restoring divider for the daylight position, one quotient bit a cycle,
// with an up-front saturation check
// ----------------------------------------------------------------------------
module dsi_pos_div import dsi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    neg,
	input  logic [TIME_W-1:0]       mag,
	input  logic [TIME_W-1:0]       span,
	output logic                    done,
	output logic signed [POS_W-1:0] pos
);

	localparam int QW = POS_W - 1;
	localparam int SH = QW - 16;
	localparam logic [4:0] STEPS = 5'(QW);

	logic              run_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [TIME_W-1:0] rem_q;
	logic [QW-1:0]     dvd_q;
	logic [QW-1:0]     quo_q;
	logic [TIME_W-1:0] span_q;
	logic              neg_q;
	logic              sat_q;
	logic [TIME_W:0]   trial;
	logic              ge;
	logic              sat;
	logic [POS_W-1:0]  q_ext;

	// quotient would reach 2^23 exactly when mag >= span * 2^7
	assign sat = {{SH{1'b0}}, mag} >= {span, {SH{1'b0}}};
	assign trial = {rem_q, dvd_q[QW-1]};
	assign ge = trial >= {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= !sat;
				done_q <= sat;
				cnt_q <= STEPS;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= sat;
			neg_q <= neg;
			span_q <= span;
			rem_q <= {{SH{1'b0}}, mag[TIME_W-1:SH]};
			dvd_q <= {mag[SH-1:0], 16'd0};
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? TIME_W'(trial - {1'b0, span_q}) : trial[TIME_W-1:0];
			dvd_q <= {dvd_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign q_ext = {1'b0, quo_q};
	assign done = done_q;

	always_comb begin
		if (sat_q)
			pos = neg_q ? POS_MIN : POS_MAX;
		else
			pos = neg_q ? -$signed(q_ext) : $signed(q_ext);
	end

endmodule

// ----- rtl/dsi_lerp.sv -----
// ----------------------------------------------------------------------------
// dsi_lerp
// three-lane linear interpolation: one multiply, then a shared-count
// restoring divide of 16 steps in each lane
// ----------------------------------------------------------------------------
module dsi_lerp import dsi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  setting_t         lo,
	input  setting_t         hi,
	input  logic [POS_W-1:0] off,
	input  logic [POS_W-1:0] span,
	output logic             done,
	output setting_t         res
);

	localparam int LANES = 3;
	localparam int PW = COLOR_W + POS_W;
	localparam logic [4:0] STEPS = 5'(COLOR_W);

	logic               mul_q;
	logic               run_q;
	logic               done_q;
	logic [4:0]         cnt_q;
	logic [POS_W-1:0]   off_q;
	logic [POS_W-1:0]   d_q;
	logic               on_q;
	logic [COLOR_W-1:0] lo_v [LANES];
	logic [COLOR_W-1:0] hi_v [LANES];
	logic [COLOR_W-1:0] base_q [LANES];
	logic [COLOR_W-1:0] mag_q [LANES];
	logic               neg_q [LANES];
	logic [POS_W-1:0]   rem_q [LANES];
	logic [COLOR_W-1:0] dvd_q [LANES];
	logic [COLOR_W-1:0] quo_q [LANES];
	logic [PW-1:0]      prod [LANES];
	logic [POS_W:0]     trial [LANES];
	logic               ge [LANES];
	logic [COLOR_W-1:0] out_v [LANES];

	assign lo_v[0] = lo.x;
	assign lo_v[1] = lo.y;
	assign lo_v[2] = {{(COLOR_W-BRI_W){1'b0}}, lo.bri};
	assign hi_v[0] = hi.x;
	assign hi_v[1] = hi.y;
	assign hi_v[2] = {{(COLOR_W-BRI_W){1'b0}}, hi.bri};

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			prod[i] = PW'(mag_q[i]) * PW'(off_q);
			trial[i] = {rem_q[i], dvd_q[i][COLOR_W-1]};
			ge[i] = trial[i] >= {1'b0, d_q};
			out_v[i] = neg_q[i] ? base_q[i] - quo_q[i] : base_q[i] + quo_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q <= 1'b0;
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			mul_q <= start;
			if (mul_q) begin
				run_q <= 1'b1;
				cnt_q <= STEPS;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			off_q <= off;
			d_q <= span;
			on_q <= lo.on;
		end
		for (int i = 0; i < LANES; i++) begin
			if (start) begin
				base_q[i] <= lo_v[i];
				neg_q[i] <= hi_v[i] < lo_v[i];
				mag_q[i] <= (hi_v[i] < lo_v[i]) ? lo_v[i] - hi_v[i] : hi_v[i] - lo_v[i];
			end else if (mul_q) begin
				// quotient stays below 2^16 since off <= span
				rem_q[i] <= prod[i][PW-1:COLOR_W];
				dvd_q[i] <= prod[i][COLOR_W-1:0];
				quo_q[i] <= '0;
			end else if (run_q) begin
				rem_q[i] <= ge[i] ? POS_W'(trial[i] - {1'b0, d_q}) : trial[i][POS_W-1:0];
				dvd_q[i] <= {dvd_q[i][COLOR_W-2:0], 1'b0};
				quo_q[i] <= {quo_q[i][COLOR_W-2:0], ge[i]};
			end
		end
	end

	assign done = done_q;
	assign res.x = out_v[0];
	assign res.y = out_v[1];
	assign res.bri = out_v[2][BRI_W-1:0];
	assign res.on = on_q;

endmodule

// ----- rtl/daylight_schedule_interpolator.sv -----
// ----------------------------------------------------------------------------
// daylight_schedule_interpolator
// breakpoint table with daylight position mapping and linear interpolation
// ----------------------------------------------------------------------------
// One request at a time: busy is high from the cycle after an evaluate
// request is taken until its result strobe. A load request, or an evaluate
// with a non-positive span, gives its result on done in the next cycle and
// never raises busy. An evaluate runs the position divider (a start step,
// 23 quotient bits at one a cycle, a done step; a saturating position
// skips the bits), the first table read, one compare per entry up to the
// first breakpoint not below the position or the last entry, then, when it
// lands between two breakpoints, the interpolator (a multiply step, 16 divide
// steps and a done step), and a last step to register the result. An empty
// table ends after the divider, with no table read or compare. The result
// is on the ports for exactly one cycle with done high; the receiver cannot
// hold it off, so sample it then.
// Configuration writes are always ready and belong in idle time only.
// ----------------------------------------------------------------------------
module daylight_schedule_interpolator import dsi_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      start,
	output logic                      busy,
	input  logic                      action,
	input  logic [3:0]                entry_index,
	input  logic signed [POS_W-1:0]   entry_position,
	input  logic [COLOR_W-1:0]        entry_color_x,
	input  logic [COLOR_W-1:0]        entry_color_y,
	input  logic [BRI_W-1:0]          entry_brightness,
	input  logic                      entry_on,
	input  logic [TIME_W-1:0]         current_time,
	// result channel
	output logic                      done,
	output logic [1:0]                status,
	output logic signed [POS_W-1:0]   daylight_position,
	output logic                      light_on,
	output logic [COLOR_W-1:0]        color_x,
	output logic [COLOR_W-1:0]        color_y,
	output logic [BRI_W-1:0]          brightness,
	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [TIME_W-1:0]         cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t state_q, state_d;

	// configuration registers
	logic [TIME_W-1:0] sunrise_q;
	logic [TIME_W-1:0] sunset_q;
	logic [4:0]        count_q;

	// evaluate context
	logic [TIME_W-1:0]       mag_q;
	logic                    neg_q;
	logic [TIME_W-1:0]       span_q;
	logic [CW-1:0]           n_q;
	logic                    divgo_q;
	logic signed [POS_W-1:0] pos_q;
	logic [CW-1:0]           idx_q;
	logic signed [POS_W-1:0] prev_pos_q;
	setting_t                prev_set_q;

	// result registers
	logic                    done_q;
	status_t                 status_q;
	logic signed [POS_W-1:0] res_pos_q;
	setting_t                res_set_q;

	logic                    accept;
	logic                    is_eval;
	logic                    span_ok;
	logic [CW-1:0]           n_clamp;
	logic                    wr_en;
	setting_t                wr_set;
	logic [AW-1:0]           rd_addr;
	logic signed [POS_W-1:0] rd_pos;
	setting_t                rd_set;
	logic                    div_done;
	logic signed [POS_W-1:0] div_pos;
	logic                    less;
	logic                    last;
	logic [CW-1:0]           idx_inc;
	logic                    lerp_start;
	logic                    lerp_done;
	setting_t                lerp_res;
	logic signed [POS_W:0]   off_w;
	logic signed [POS_W:0]   dist_w;

	assign accept = start && !busy;
	assign is_eval = action_t'(action) == ACT_EVAL;
	assign span_ok = sunset_q > sunrise_q;
	assign cfg_ready = 1'b1;

	// counts above the table depth act as the depth
	assign n_clamp = (32'(count_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(count_q);

	// load requests into slots past the depth are dropped
	assign wr_en = accept && !is_eval && (32'(entry_index) < TABLE_DEPTH);
	assign wr_set = '{on: entry_on, bri: entry_brightness, y: entry_color_y, x: entry_color_x};

	// search walk: compare entry idx while the next one is read
	assign idx_inc = CW'(idx_q + 1'b1);
	assign rd_addr = (state_q == S_CMP) ? idx_inc[AW-1:0] : idx_q[AW-1:0];
	assign less = rd_pos < pos_q;
	assign last = idx_inc == n_q;

	assign off_w = {pos_q[POS_W-1], pos_q} - {prev_pos_q[POS_W-1], prev_pos_q};
	assign dist_w = {rd_pos[POS_W-1], rd_pos} - {prev_pos_q[POS_W-1], prev_pos_q};

	dsi_table #(
		.DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_table (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(AW'(entry_index)),
		.wr_pos(entry_position),
		.wr_set(wr_set),
		.rd_addr(rd_addr),
		.rd_pos(rd_pos),
		.rd_set(rd_set)
	);

	dsi_pos_div u_pos_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(divgo_q),
		.neg(neg_q),
		.mag(mag_q),
		.span(span_q),
		.done(div_done),
		.pos(div_pos)
	);

	dsi_lerp u_lerp (
		.clk(clk),
		.arst_n(arst_n),
		.start(lerp_start),
		.lo(prev_set_q),
		.hi(rd_set),
		.off(off_w[POS_W-1:0]),
		.span(dist_w[POS_W-1:0]),
		.done(lerp_done),
		.res(lerp_res)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// next state and unit starts
	always_comb begin
		state_d = state_q;
		lerp_start = 1'b0;
		busy = state_q != S_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (accept && is_eval && span_ok)
					state_d = S_DIV;
			end
			S_DIV: begin
				if (div_done)
					state_d = (n_q == '0) ? S_IDLE : S_READ;
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (!less) begin
					// before the first entry clamps, otherwise interpolate
					if (idx_q == '0) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_LERP;
						lerp_start = 1'b1;
					end
				end else if (last) begin
					state_d = S_IDLE;
				end
			end
			S_LERP: begin
				if (lerp_done)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sunrise_q <= '0;
			sunset_q <= 32'd1;
			count_q <= '0;
			done_q <= 1'b0;
			divgo_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			divgo_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SUNRISE: sunrise_q <= cfg_data;
					CFG_SUNSET:  sunset_q <= cfg_data;
					CFG_COUNT:   count_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						done_q <= !is_eval || !span_ok;
						divgo_q <= is_eval && span_ok;
					end
				end
				S_DIV:  done_q <= div_done && (n_q == '0);
				S_CMP:  done_q <= !less ? (idx_q == '0) : last;
				S_LERP: done_q <= lerp_done;
				default: ;
			endcase
		end
	end

	// datapath and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_q <= !is_eval ? ST_STORED : ST_SPAN;
					res_pos_q <= '0;
					res_set_q <= '0;
					neg_q <= current_time < sunrise_q;
					mag_q <= (current_time < sunrise_q) ? sunrise_q - current_time
					                                    : current_time - sunrise_q;
					span_q <= sunset_q - sunrise_q;
					n_q <= n_clamp;
				end
			end
			S_DIV: begin
				if (div_done) begin
					pos_q <= div_pos;
					idx_q <= '0;
					status_q <= ST_EMPTY;
					res_pos_q <= div_pos;
					res_set_q <= '0;
				end
			end
			S_CMP: begin
				status_q <= ST_EVAL;
				res_pos_q <= pos_q;
				res_set_q <= rd_set;
				if (less) begin
					idx_q <= idx_inc;
					prev_pos_q <= rd_pos;
					prev_set_q <= rd_set;
				end
			end
			S_LERP: begin
				res_set_q <= lerp_res;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign status = status_q;
	assign daylight_position = res_pos_q;
	assign light_on = res_set_q.on;
	assign color_x = res_set_q.x;
	assign color_y = res_set_q.y;
	assign brightness = res_set_q.bri;

	// the search never compares past the loaded entries
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (idx_q < n_q))
		else $error("table walk beyond entry count");

	// busy only rises after an evaluate request
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ($past(start) && $past(action) == ACT_EVAL))
		else $error("busy without evaluate request");

	// interpolation end gives an evaluated result next cycle
	a_lerp_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LERP && lerp_done) |=> (done && status == ST_EVAL))
		else $error("interpolation result missing");

	// a span error carries no setting
	a_span_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_SPAN) |-> (!light_on && color_x == '0 &&
		daylight_position == '0))
		else $error("span error with payload");

endmodule
